[rtl/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

[rtl/pale_pkg.sv]
// Types, codes and defaults of the positional array list engine.
package pale_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 256;
  localparam int unsigned DEF_WORD_BITS   = 32;

  localparam int unsigned POS_W      = 9;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned WORD_MAX_W = 64;
  localparam int unsigned CNT_MAX_W  = 17;

  typedef enum logic [2:0] {
    ACT_PUSH_END,
    ACT_POP_END,
    ACT_INSERT,
    ACT_ERASE,
    ACT_READ,
    ACT_WRITE,
    ACT_SEARCH,
    ACT_CLEAR
  } action_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_POS,
    ST_EMPTY,
    ST_FULL
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_SHIFT,
    B_DRAIN,
    B_READ,
    B_FINAL
  } back_state_e;

  typedef struct packed {
    action_e            action;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic               found;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    action_e               action;
    status_e               status;
    logic [POS_W-1:0]      position;
    logic [WORD_MAX_W-1:0] value;
    logic [CNT_MAX_W-1:0]  cnt_before;
    logic [COUNT_W-1:0]    count_after;
  } cmd_t;

endpackage

[rtl/pale_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pale_front.sv]
// Request classifier: checks each request against the count and tracks the count.
`include "assert_macros.svh"

module pale_front #(
  parameter int unsigned MAX_ENTRIES = pale_pkg::DEF_MAX_ENTRIES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  pale_pkg::req_t  req_i,
  output pale_pkg::cmd_t  cmd_o
);

  import pale_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW  = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_new;
  logic [CMPW-1:0]  pos_c, cnt_c;
  logic             full, empty;
  status_e          status;

  assign pos_c = CMPW'(req_i.position);
  assign cnt_c = CMPW'(cnt_q);
  assign full  = (cnt_q == CNT_W'(MAX_ENTRIES));
  assign empty = (cnt_q == '0);

  always_comb begin
    status  = ST_OK;
    cnt_new = cnt_q;
    unique case (req_i.action) inside
      ACT_PUSH_END: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cnt_new = cnt_q + 1'b1;
        end
      end
      ACT_POP_END: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cnt_new = cnt_q - 1'b1;
        end
      end
      ACT_INSERT: begin
        if (pos_c > cnt_c) begin
          status = ST_BAD_POS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cnt_new = cnt_q + 1'b1;
        end
      end
      ACT_ERASE: begin
        if (pos_c >= cnt_c) begin
          status = ST_BAD_POS;
        end else begin
          cnt_new = cnt_q - 1'b1;
        end
      end
      ACT_READ, ACT_WRITE: begin
        if (pos_c >= cnt_c) begin
          status = ST_BAD_POS;
        end
      end
      ACT_SEARCH: begin
        status = ST_OK;
      end
      ACT_CLEAR: begin
        cnt_new = '0;
      end
    endcase
  end

  assign cnt_d = accept_i ? cnt_new : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    cmd_o.action      = req_i.action;
    cmd_o.status      = status;
    cmd_o.position    = req_i.position;
    cmd_o.value       = WORD_MAX_W'(req_i.value);
    cmd_o.cnt_before  = CNT_MAX_W'(cnt_q);
    cmd_o.count_after = COUNT_W'(cnt_new);
  end

  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(MAX_ENTRIES), "count above capacity")

endmodule

[rtl/pale_fifo.sv]
// Two-entry command queue between the classifier and the executor.
`include "assert_macros.svh"

module pale_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pale_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pale_pkg::cmd_t  cmd_o
);

  import pale_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign cmd_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    fill_d = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")

endmodule

[rtl/pale_back.sv]
// Command executor: runs each queued request against the element store.
`include "assert_macros.svh"

module pale_back #(
  parameter int unsigned MAX_ENTRIES = pale_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned WORD_BITS   = pale_pkg::DEF_WORD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pale_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output logic            done_o,
  output pale_pkg::rsp_t  rsp_o
);

  import pale_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW  = (CNT_W > POS_W) ? CNT_W : POS_W;

  back_state_e    state_q, state_d;
  cmd_t           cmd_q, cmd_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [AW-1:0]  wb_addr_q, wb_addr_d;
  logic           rvalid_q, rvalid_d;
  logic           match_q, match_d;
  logic           done_q, done_d;
  rsp_t           rsp_q, rsp_d;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic [CNT_W-1:0]     cnt_b;
  logic [AW-1:0]        pos_a, last_idx;
  logic [WORD_BITS-1:0] val_w;
  logic                 hit, shift_op;

  assign cnt_b    = CNT_W'(cmd_q.cnt_before);
  assign pos_a    = AW'(cmd_q.position);
  assign val_w    = WORD_BITS'(cmd_q.value);
  assign hit      = (rdata == val_w);
  assign shift_op = (cmd_q.action == ACT_INSERT) || (cmd_q.action == ACT_ERASE);
  assign last_idx = (cmd_q.action == ACT_INSERT) ? pos_a : AW'(cnt_b - 1'b1);

  pale_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    wb_addr_d = wb_addr_q;
    rvalid_d  = 1'b0;
    match_d   = match_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = pos_a;
    wdata     = val_w;
    re        = 1'b0;
    raddr     = idx_q;

    // write back (insert, erase) or compare (search) the word read in the previous cycle
    if (rvalid_q) begin
      if (shift_op) begin
        we    = 1'b1;
        waddr = wb_addr_q;
        wdata = rdata;
      end
      match_d = match_q | hit;
    end

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        rsp_d.read_value = '0;
        rsp_d.found      = 1'b0;
        rsp_d.status     = cmd_q.status;
        rsp_d.count      = cmd_q.count_after;
        if (cmd_q.status != ST_OK) begin
          done_d  = 1'b1;
          state_d = B_IDLE;
        end else begin
          unique case (cmd_q.action) inside
            ACT_PUSH_END: begin
              we      = 1'b1;
              waddr   = AW'(cnt_b);
              done_d  = 1'b1;
              state_d = B_IDLE;
            end
            ACT_WRITE: begin
              we      = 1'b1;
              done_d  = 1'b1;
              state_d = B_IDLE;
            end
            ACT_READ: begin
              re      = 1'b1;
              raddr   = pos_a;
              state_d = B_READ;
            end
            ACT_INSERT: begin
              if (CMPW'(cmd_q.position) == CMPW'(cnt_b)) begin
                we      = 1'b1;
                done_d  = 1'b1;
                state_d = B_IDLE;
              end else begin
                idx_d   = AW'(cnt_b - 1'b1);
                state_d = B_SHIFT;
              end
            end
            ACT_ERASE: begin
              if (CMPW'(cmd_q.position) + 1'b1 == CMPW'(cnt_b)) begin
                done_d  = 1'b1;
                state_d = B_IDLE;
              end else begin
                idx_d   = pos_a + 1'b1;
                state_d = B_SHIFT;
              end
            end
            ACT_SEARCH: begin
              match_d = 1'b0;
              if (cnt_b == '0) begin
                done_d  = 1'b1;
                state_d = B_IDLE;
              end else begin
                idx_d   = '0;
                state_d = B_SHIFT;
              end
            end
            ACT_POP_END, ACT_CLEAR: begin
              done_d  = 1'b1;
              state_d = B_IDLE;
            end
          endcase
        end
      end
      B_SHIFT: begin
        re        = 1'b1;
        raddr     = idx_q;
        rvalid_d  = 1'b1;
        wb_addr_d = (cmd_q.action == ACT_INSERT) ? idx_q + 1'b1 : idx_q - 1'b1;
        if (idx_q == last_idx) begin
          state_d = B_DRAIN;
        end else begin
          idx_d = (cmd_q.action == ACT_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
        end
      end
      B_DRAIN: begin
        if (cmd_q.action == ACT_INSERT) begin
          state_d = B_FINAL;
        end else begin
          rsp_d.found = (cmd_q.action == ACT_SEARCH) && (match_q || hit);
          done_d      = 1'b1;
          state_d     = B_IDLE;
        end
      end
      B_READ: begin
        rsp_d.read_value = VAL_W'(rdata);
        done_d           = 1'b1;
        state_d          = B_IDLE;
      end
      B_FINAL: begin
        we      = 1'b1;
        done_d  = 1'b1;
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    wb_addr_q <= wb_addr_d;
    match_q   <= match_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_CLK(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "back-to-back result strobes")
  `ASSERT_NEVER(a_pop_idle, clk_i, rst_ni, pop_o && (state_q != B_IDLE), "pop while busy")

endmodule

[rtl/positional_array_list_engine_top.sv]
// Top level of the positional array list engine.
//
// Usage: drive req_i and raise start; the request is taken at a rising edge
// where start is high and busy is low. busy rises while the two-entry request
// queue is full. Each request yields exactly one result on rsp_o, valid for
// the single cycle in which done_o is high; results come in request order and
// the receiver cannot hold them off.
// Push, pop, write, clear, an insert at the end, an erase of the last word, a
// search of an empty list and any request that fails its check need no store
// read; a read reads one word; an insert moves the words from its position up
// and then writes the new word; an erase moves the words behind its position
// down; a search scans all count words. The executor moves or scans one word
// per cycle through the single read and single write port of the element store
// and takes a new request only once it has finished the last one; up to two
// further requests queue meanwhile.
// Reset clears the count, the queue and the executor; stored words keep
// whatever they held and are reached only once written again.
module positional_array_list_engine_top #(
  parameter int unsigned MAX_ENTRIES = pale_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned WORD_BITS   = pale_pkg::DEF_WORD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pale_pkg::req_t  req_i,
  output logic            done_o,
  output pale_pkg::rsp_t  rsp_o
);

  import pale_pkg::*;

  logic accept;
  logic q_full, q_empty, q_pop;
  cmd_t front_cmd, queue_cmd;

  assign busy   = q_full;
  assign accept = start && !q_full;

  pale_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .cmd_o    (front_cmd)
  );

  pale_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (queue_cmd)
  );

  pale_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WORD_BITS   (WORD_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .cmd_i   (queue_cmd),
    .pop_o   (q_pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

[bench/positional_array_list_engine_top_test.sv]
// Self-checking bench for the positional array list engine: directed and random requests.
`timescale 1ns / 1ps

module positional_array_list_engine_top_test;
  import pale_pkg::*;

  localparam int unsigned CAPACITY = DEF_MAX_ENTRIES;

  class list_tracker;
    logic [VAL_W-1:0] words [CAPACITY];
    int unsigned      level;
    rsp_t             pending_rsp [$];
    int unsigned      failures;

    function new();
      level    = 0;
      failures = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned i;
      e        = '0;
      e.status = ST_OK;
      case (r.action)
        ACT_PUSH_END: begin
          if (level >= CAPACITY) begin
            e.status = ST_FULL;
          end else begin
            words[level] = r.value;
            level++;
          end
        end
        ACT_POP_END: begin
          if (level == 0) e.status = ST_EMPTY;
          else level--;
        end
        ACT_INSERT: begin
          if (r.position > level) begin
            e.status = ST_BAD_POS;
          end else if (level >= CAPACITY) begin
            e.status = ST_FULL;
          end else begin
            for (i = level; i > r.position; i--) words[i] = words[i-1];
            words[r.position] = r.value;
            level++;
          end
        end
        ACT_ERASE: begin
          if (r.position >= level) begin
            e.status = ST_BAD_POS;
          end else begin
            for (i = r.position; i + 1 < level; i++) words[i] = words[i+1];
            level--;
          end
        end
        ACT_READ: begin
          if (r.position >= level) e.status = ST_BAD_POS;
          else e.read_value = words[r.position];
        end
        ACT_WRITE: begin
          if (r.position >= level) e.status = ST_BAD_POS;
          else words[r.position] = r.value;
        end
        ACT_SEARCH: begin
          for (i = 0; i < level; i++) begin
            if (words[i] == r.value) begin
              e.found = 1'b1;
              break;
            end
          end
        end
        default: begin
          level = 0;
        end
      endcase
      e.count = level[COUNT_W-1:0];
      pending_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: %h", got);
        failures++;
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %h, actual %h", exp.read_value, got.read_value);
        failures++;
      end
      if (got.found !== exp.found) begin
        $error("found: expected %b, actual %b", exp.found, got.found);
        failures++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %s, actual %s", exp.status.name(), got.status.name());
        failures++;
      end
      if (got.count !== exp.count) begin
        $error("count: expected %0d, actual %0d", exp.count, got.count);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  list_tracker tracker = new();
  int unsigned idle_pct;

  positional_array_list_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_response(rsp_o);
  end

  task automatic send_request(req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_request(r);
  endtask

  task automatic issue(action_e act, int unsigned pos, logic [VAL_W-1:0] val);
    req_t r;
    r.action   = act;
    r.position = pos[POS_W-1:0];
    r.value    = val;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    send_request(r);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3 || (sel >= 6 && tracker.level == 0)) return $urandom;
    if (sel == 4) return '0;
    if (sel == 5) return '1;
    return tracker.words[$urandom_range(0, tracker.level - 1)];
  endfunction

  function automatic int unsigned pick_position(action_e act);
    int unsigned sel;
    int unsigned lvl;
    sel = $urandom_range(0, 9);
    lvl = tracker.level;
    if (sel == 7) return lvl;
    if (sel == 8) return lvl + 1;
    if (sel == 9) return $urandom_range(0, 511);
    if (act == ACT_INSERT) return $urandom_range(0, lvl);
    return (lvl == 0) ? 0 : $urandom_range(0, lvl - 1);
  endfunction

  task automatic random_request();
    action_e     act;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (tracker.level > 48 && $urandom_range(0, 1) == 1) begin
      act = (w < 50) ? ACT_POP_END : ACT_ERASE;
    end else if (w < 22) begin
      act = ACT_PUSH_END;
    end else if (w < 32) begin
      act = ACT_POP_END;
    end else if (w < 47) begin
      act = ACT_INSERT;
    end else if (w < 61) begin
      act = ACT_ERASE;
    end else if (w < 74) begin
      act = ACT_READ;
    end else if (w < 84) begin
      act = ACT_WRITE;
    end else if (w < 97) begin
      act = ACT_SEARCH;
    end else begin
      act = ACT_CLEAR;
    end
    issue(act, pick_position(act), pick_value());
  endtask

  task automatic fill_and_probe();
    while (tracker.level < CAPACITY) issue(ACT_PUSH_END, $urandom_range(0, 511), pick_value());
    issue(ACT_PUSH_END, 0, $urandom);
    issue(ACT_INSERT, 0, $urandom);
    issue(ACT_INSERT, CAPACITY, $urandom);
    issue(ACT_INSERT, CAPACITY + 1, $urandom);
    issue(ACT_READ, CAPACITY - 1, 0);
    issue(ACT_READ, CAPACITY, 0);
    issue(ACT_WRITE, CAPACITY - 1, $urandom);
    issue(ACT_READ, CAPACITY - 1, 0);
    issue(ACT_SEARCH, 0, tracker.words[CAPACITY - 1]);
    issue(ACT_SEARCH, 0, $urandom);
    issue(ACT_ERASE, 0, 0);
    issue(ACT_INSERT, 0, $urandom);
    issue(ACT_ERASE, CAPACITY - 1, 0);
    issue(ACT_POP_END, 0, 0);
    issue(ACT_SEARCH, 0, tracker.words[0]);
    issue(ACT_CLEAR, 0, 0);
  endtask

  initial begin
    idle_pct = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(ACT_POP_END, 0, 0);
    issue(ACT_READ, 0, 0);
    issue(ACT_ERASE, 0, 0);
    issue(ACT_WRITE, 0, 32'h1111_1111);
    issue(ACT_SEARCH, 0, 0);
    issue(ACT_INSERT, 1, 32'h2222_2222);
    issue(ACT_INSERT, 0, 32'hFFFF_FFFF);
    issue(ACT_PUSH_END, 0, 32'h0000_0000);
    issue(ACT_PUSH_END, 0, 32'hA5A5_A5A5);
    issue(ACT_INSERT, 1, 32'h1234_5678);
    issue(ACT_INSERT, 4, 32'h5A5A_5A5A);
    issue(ACT_READ, 0, 0);
    issue(ACT_READ, 4, 0);
    issue(ACT_READ, 5, 0);
    issue(ACT_READ, 511, 0);
    issue(ACT_WRITE, 2, 32'hDEAD_BEEF);
    issue(ACT_SEARCH, 0, 32'h0000_0000);
    issue(ACT_SEARCH, 0, 32'hDEAD_BEEF);
    issue(ACT_SEARCH, 0, 32'h0000_0001);
    issue(ACT_ERASE, 0, 0);
    issue(ACT_ERASE, 3, 0);
    issue(ACT_ERASE, 3, 0);
    issue(ACT_POP_END, 0, 0);
    issue(ACT_CLEAR, 0, 0);
    issue(ACT_PUSH_END, 0, 32'h0000_0001);
    issue(ACT_READ, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 32 : (phase == 1) ? 59 : 0;
      for (int n = 0; n < 230; n++) begin
        if (n == 115) fill_and_probe();
        random_request();
      end
    end

    start <= 1'b0;
    while (tracker.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
